FILE: design/tkh_pkg.sv
// ----------------------------------------------------------------------------
// tkh_pkg
// Shared types and constants of the TEA keyed hash: reset values of the
// configuration registers, the TEA round constant and the job format passed
// from the byte packer to the round engine.
// ----------------------------------------------------------------------------
package tkh_pkg;

  localparam logic [31:0] TEA_DELTA          = 32'h9E37_79B9;
  localparam logic [31:0] KEY_HIGH_RESET     = 32'h9464_A485;
  localparam logic [31:0] KEY_LOW_RESET      = 32'h542E_1A94;
  localparam logic [5:0]  BLOCK_ROUNDS_RESET = 6'd6;
  localparam logic [5:0]  FINAL_ROUNDS_RESET = 6'd10;

  // Register values seen by the datapath
  typedef struct packed {
    logic [31:0] key_high;
    logic [31:0] key_low;
    logic [5:0]  block_rounds;
    logic [5:0]  final_rounds;
  } cfg_t;

  // One block of work for the round engine
  typedef struct packed {
    logic [3:0][31:0] word;
    logic [5:0]       rounds;
    logic             is_final;
    logic             too_long;
  } job_t;

  // Up to two jobs queued in one cycle; b is only valid together with a
  typedef struct packed {
    logic a_valid;
    logic b_valid;
    job_t a;
    job_t b;
  } push_t;

endpackage

FILE: design/tkh_msg_if.sv
// ----------------------------------------------------------------------------
// tkh_msg_if
// Message byte channel: valid/ready handshake with one byte and its flags.
// ----------------------------------------------------------------------------
interface tkh_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_item;

  modport source (output valid, output data_byte, output has_byte, output last_item,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last_item,
                output ready);
endinterface

FILE: design/tkh_hash_if.sv
// ----------------------------------------------------------------------------
// tkh_hash_if
// Hash result channel: valid/ready handshake with the hash word and its flag.
// ----------------------------------------------------------------------------
interface tkh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  logic        too_long;

  modport source (output valid, output hash_value, output too_long, input ready);
  modport sink (input valid, input hash_value, input too_long, output ready);
endinterface

FILE: design/tkh_cfg.sv
// ----------------------------------------------------------------------------
// tkh_cfg
// APB register file: hash key words and the two round counts.
// ----------------------------------------------------------------------------
module tkh_cfg
  import tkh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  localparam logic [1:0] REG_KEY_HIGH     = 2'd0;
  localparam logic [1:0] REG_KEY_LOW      = 2'd1;
  localparam logic [1:0] REG_BLOCK_ROUNDS = 2'd2;
  localparam logic [1:0] REG_FINAL_ROUNDS = 2'd3;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  // Write registers in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_high     <= KEY_HIGH_RESET;
      cfg.key_low      <= KEY_LOW_RESET;
      cfg.block_rounds <= BLOCK_ROUNDS_RESET;
      cfg.final_rounds <= FINAL_ROUNDS_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KEY_HIGH:     cfg.key_high     <= pwdata;
        REG_KEY_LOW:      cfg.key_low      <= pwdata;
        REG_BLOCK_ROUNDS: cfg.block_rounds <= pwdata[5:0];
        REG_FINAL_ROUNDS: cfg.final_rounds <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_KEY_HIGH:     prdata = cfg.key_high;
      REG_KEY_LOW:      prdata = cfg.key_low;
      REG_BLOCK_ROUNDS: prdata = {26'd0, cfg.block_rounds};
      REG_FINAL_ROUNDS: prdata = {26'd0, cfg.final_rounds};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

FILE: design/tkh_front.sv
// ----------------------------------------------------------------------------
// tkh_front
// Byte packer: collects message bytes into a 16-byte block, tracks the
// message length and builds block and final jobs for the round engine.
// ----------------------------------------------------------------------------
module tkh_front
  import tkh_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  tkh_msg_if.sink     msg,
  input  cfg_t        cfg,
  input  logic        room,
  output push_t       push
);

  logic [7:0]             store [16];
  logic [15:0][7:0]       store_eff;
  logic [3:0]             fill;
  logic [3:0]             fill_next;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] len_next;
  logic                   ovf;
  logic                   ovf_next;
  logic                   acc;
  logic                   take;
  logic                   fin;
  logic                   blk_done;
  logic [1:0]             q;
  logic [1:0]             m;
  logic [31:0]            len32;
  logic [31:0]            pad_half;
  logic [31:0]            pad;
  logic [3:0][31:0]       blk_w;
  logic [3:0][31:0]       fin_w;
  job_t                   blk_job;
  job_t                   fin_job;

  function automatic logic [31:0] sx8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] pack_word(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
    return sx8(b0) | (sx8(b1) << 8) | (sx8(b2) << 16) | (sx8(b3) << 24);
  endfunction

  assign msg.ready = room;
  assign acc       = msg.valid & msg.ready;
  assign take      = acc & msg.has_byte;
  assign fin       = acc & msg.last_item;
  assign blk_done  = take && (fill == 4'd15);
  assign fill_next = fill + {3'd0, take};
  assign len_next  = len + LENGTH_BITS'(take);
  assign ovf_next  = ovf | (take && (len == '1));

  // View the store with this cycle's byte already written
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      store_eff[i] = (take && (fill == 4'(i))) ? msg.data_byte : store[i];
    end
  end

  // Pack full-block words
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      blk_w[k] = pack_word(store_eff[4*k], store_eff[4*k+1],
                           store_eff[4*k+2], store_eff[4*k+3]);
    end
  end

  // Build the length pad and the final block from leftover bytes
  assign len32    = 32'(len_next);
  assign pad_half = len32 | (len32 << 8);
  assign pad      = pad_half | (pad_half << 16);
  assign q        = fill_next[3:2];
  assign m        = fill_next[1:0];

  always_comb begin
    logic [31:0] part;
    for (int k = 0; k < 4; k++) begin
      part = pad;
      for (int j = 0; j < 3; j++) begin
        if (2'(j) < m) begin
          part = (part << 8) | sx8(store_eff[4*k+j]);
        end
      end
      if (2'(k) < q) begin
        fin_w[k] = blk_w[k];
      end else if (2'(k) == q) begin
        fin_w[k] = part;
      end else begin
        fin_w[k] = pad;
      end
    end
  end

  // Form jobs; a byte that closes a block on the last item queues two
  always_comb begin
    blk_job.word     = blk_w;
    blk_job.rounds   = cfg.block_rounds;
    blk_job.is_final = 1'b0;
    blk_job.too_long = 1'b0;
    fin_job.word     = fin_w;
    fin_job.rounds   = cfg.final_rounds;
    fin_job.is_final = 1'b1;
    fin_job.too_long = ovf_next;
    push.a_valid     = blk_done | fin;
    push.b_valid     = blk_done & fin;
    push.a           = blk_done ? blk_job : fin_job;
    push.b           = fin_job;
  end

  // Hold bytes of the current block
  always_ff @(posedge clk) begin
    if (take) begin
      store[fill] <= msg.data_byte;
    end
  end

  // Advance fill and length; clear at message end
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      len  <= '0;
      ovf  <= 1'b0;
    end else if (acc) begin
      fill <= fin ? '0 : fill_next;
      len  <= fin ? '0 : len_next;
      ovf  <= fin ? 1'b0 : ovf_next;
    end
  end

endmodule

FILE: design/tkh_queue.sv
// ----------------------------------------------------------------------------
// tkh_queue
// Four-entry job queue between the byte packer and the round engine.
// Takes up to two jobs per cycle and hands out one.
// ----------------------------------------------------------------------------
module tkh_queue
  import tkh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  input  logic  pop,
  output logic  head_valid,
  output job_t  head
);

  job_t       slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] push_n;

  assign push_n     = {1'b0, push.a_valid} + {1'b0, push.b_valid};
  assign room       = (count <= 3'd2);
  assign head_valid = (count != 3'd0);
  assign head       = slots[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      slots[wr_ptr] <= push.a;
    end
    if (push.b_valid) begin
      slots[wr_ptr + 2'd1] <= push.b;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

FILE: design/tkh_back.sv
// ----------------------------------------------------------------------------
// tkh_back
// Round engine: runs TEA rounds, one half-round per cycle, on each job,
// folds the result into the chaining words and emits the hash on final jobs.
// ----------------------------------------------------------------------------
module tkh_back
  import tkh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  tkh_hash_if.source hash
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HIGH = 2'd1;
  localparam logic [1:0] ST_LOW  = 2'd2;
  localparam logic [1:0] ST_FOLD = 2'd3;

  logic [1:0]  state;
  job_t        cur;
  logic [31:0] x0;
  logic [31:0] x1;
  logic [31:0] sum;
  logic [5:0]  left;
  logic [31:0] chain_high;
  logic [31:0] chain_low;
  logic [31:0] sum_high;
  logic [31:0] sum_low;
  logic        out_valid;
  logic [31:0] out_hash;
  logic        out_long;
  logic        out_free;

  function automatic logic [31:0] tea_f(input logic [31:0] x, input logic [31:0] wa,
                                        input logic [31:0] wb, input logic [31:0] s);
    return ((x << 4) + wa) ^ (x + s) ^ ((x >> 5) + wb);
  endfunction

  assign pop        = (state == ST_IDLE) && head_valid;
  assign out_free   = !out_valid || hash.ready;
  assign sum_high   = chain_high + x0;
  assign sum_low    = chain_low + x1;
  assign hash.valid      = out_valid;
  assign hash.hash_value = out_hash;
  assign hash.too_long   = out_long;

  // Sequence rounds and fold into the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      chain_high <= KEY_HIGH_RESET;
      chain_low  <= KEY_LOW_RESET;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            state <= ST_HIGH;
          end
        end
        ST_HIGH: state <= ST_LOW;
        ST_LOW: begin
          state <= (left == 6'd1) ? ST_FOLD : ST_HIGH;
        end
        ST_FOLD: begin
          if (!cur.is_final) begin
            chain_high <= sum_high;
            chain_low  <= sum_low;
            state      <= ST_IDLE;
          end else if (out_free) begin
            chain_high <= cfg.key_high;
            chain_low  <= cfg.key_low;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Round datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur  <= head;
        x0   <= chain_high;
        x1   <= chain_low;
        sum  <= TEA_DELTA;
        left <= (head.rounds == 6'd0) ? 6'd1 : head.rounds;
      end
      ST_HIGH: x0 <= x0 + tea_f(x1, cur.word[0], cur.word[1], sum);
      ST_LOW: begin
        x1   <= x1 + tea_f(x0, cur.word[2], cur.word[3], sum);
        sum  <= sum + TEA_DELTA;
        left <= left - 6'd1;
      end
      default: ;
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FOLD && cur.is_final && out_free) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FOLD && cur.is_final && out_free) begin
      out_hash <= sum_high ^ sum_low;
      out_long <= cur.too_long;
    end
  end

endmodule

FILE: design/tea_keyed_name_hash.sv
// ----------------------------------------------------------------------------
// tea_keyed_name_hash
// Keyed 32-bit hash of a byte stream from TEA rounds in a Davies-Meyer chain.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle on msg while msg.ready is high
// and returns one hash on hash for each item flagged last_item. A packer
// gathers 16-byte blocks and queues a job per full block, plus a padded
// final job at message end, into a four-entry queue; the round engine runs
// one TEA half-round per cycle, with a round count of 0 run as one round,
// and a final job stays in its fold state while the previous hash still
// waits in the output register. With block_rounds up to 7 a full block
// finishes while the next block's bytes arrive, and bytes stream at one per
// cycle; larger round counts or a final job hold msg.ready low once the
// queue has fewer than two free entries. The key registers are sampled
// when a message's hash is produced, so a new key applies from the message
// after the next one started.
// ----------------------------------------------------------------------------
module tea_keyed_name_hash
  import tkh_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  tkh_msg_if.sink     msg,
  tkh_hash_if.source  hash,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  push_t push;
  logic  room;
  logic  pop;
  logic  head_valid;
  job_t  head;

  // Configuration registers
  tkh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Byte packer
  tkh_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg),
    .cfg  (cfg),
    .room (room),
    .push (push)
  );

  // Job queue
  tkh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Round engine
  tkh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .hash       (hash)
  );

endmodule
